@@ hw/rtl/btcmp_pkg.sv @@
// Shared widths, constants, types and helpers of the binomial term coefficient block.
package btcmp_pkg;

  localparam int MOD_W     = 15;   // modulus and residue width
  localparam int COEF_W    = 20;   // raw coefficient width
  localparam int POW_W     = 10;   // power and exponent width
  localparam int LEN_W     = 4;    // bit length of the modulus
  localparam int MU_W      = 17;   // Barrett reciprocal, floor(2^(2L)/p)
  localparam int PROD_W    = 2 * MOD_W;
  localparam int DIV_W     = PROD_W + 1;  // wide enough for 2^(2L) with L = MOD_W
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int MAX_POWER = 1023;

  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(10007);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MU,
    ST_RED_A,
    ST_RED_B,
    ST_FACT,
    ST_CHECK,
    ST_POW,
    ST_POW_MUL,
    ST_POW_SQ,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [MOD_W-1:0] modulus;
    logic [MU_W-1:0]  mu;
    logic [LEN_W-1:0] len;
  } mm_setup_t;

  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] op_x;
    logic [MOD_W-1:0] op_y;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] value;
  } mm_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [MOD_W-1:0] remainder;
  } div_rsp_t;

  // Position of the top set bit plus one; 0 for a zero value.
  function automatic logic [LEN_W-1:0] bit_len(input logic [MOD_W-1:0] v);
    logic [LEN_W-1:0] len;
    len = '0;
    for (int i = 0; i < MOD_W; i++) begin
      if (v[i]) len = LEN_W'(i + 1);
    end
    return len;
  endfunction

endpackage

@@ hw/rtl/binomial_term_coefficient_mod_prime.sv @@
// Top level: C(k,n) * a^n * b^m modulo a configurable prime, one shared multiplier.
//
// Each transaction takes coef_a, coef_b, total_power (k), x_power (n) and y_power (m) and
// returns C(k,n)*a^n*b^m mod modulus, the coefficient of one term of (ax+by)^k. Requests
// with n > k or k >= modulus go straight to the output state with invalid set and coefficient 0;
// a modulus of one gives 0. Otherwise a bit-serial divider first forms the Barrett
// reciprocal and reduces a and b, then the Barrett modular multiplier builds k! by a
// running product, raises n! and (k-n)! to modulus-2 for their inverses, forms a^n and
// b^m by square-and-multiply and folds each into the result. One transaction is worked
// on at a time and in_stall is high meanwhile; a finished result waits in the output
// register while the next transaction is accepted. If n! or (k-n)! is zero modulo the
// modulus (only for a composite modulus) invalid is set. The user must write the modulus
// register through cfg_write/cfg_data only while idle; the block itself does not enforce
// it. The modulus register resets to 10007.
module binomial_term_coefficient_mod_prime import btcmp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_write,
  input  logic [MOD_W-1:0]  cfg_data,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [COEF_W-1:0] coef_a,
  input  logic [COEF_W-1:0] coef_b,
  input  logic [POW_W-1:0]  total_power,
  input  logic [POW_W-1:0]  x_power,
  input  logic [POW_W-1:0]  y_power,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MOD_W-1:0]  coefficient,
  output logic              invalid
);

  state_t state, state_next;

  // configuration
  logic [MOD_W-1:0]  modulus;
  logic [LEN_W-1:0]  mod_len;

  // captured transaction
  logic [COEF_W-1:0] a_in;
  logic [COEF_W-1:0] b_in;
  logic [POW_W-1:0]  k_r;
  logic [POW_W-1:0]  n_r;
  logic [POW_W-1:0]  m_r;
  logic [POW_W-1:0]  kn_r;

  // working registers
  logic [MU_W-1:0]   mu;
  logic [MOD_W-1:0]  a_res;
  logic [MOD_W-1:0]  b_res;
  logic [MOD_W-1:0]  fac;
  logic [MOD_W-1:0]  fac_n;
  logic [MOD_W-1:0]  fac_kn;
  logic [POW_W-1:0]  idx;
  logic [MOD_W-1:0]  acc;
  logic              res_inv;
  logic [MOD_W-1:0]  pw_res;
  logic [MOD_W-1:0]  pw_base;
  logic [MOD_W-1:0]  pw_exp;
  logic [1:0]        pow_sel;

  logic              req_bad;
  logic              out_load;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  mm_req_t           mm_req;
  mm_rsp_t           mm_rsp;
  mm_setup_t         mm_setup;

  assign in_stall = (state != ST_IDLE);

  // bottom above top, top not below modulus (covers a modulus of zero), top above bound
  assign req_bad = (x_power > total_power) ||
                   ({{(MOD_W-POW_W){1'b0}}, total_power} >= modulus) ||
                   (int'(total_power) > MAX_POWER);

  assign mm_setup = '{modulus: modulus, mu: mu, len: mod_len};

  btcmp_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .divisor (modulus),
    .req     (div_req),
    .rsp     (div_rsp)
  );

  btcmp_modmul u_modmul (
    .clk   (clk),
    .rst   (rst),
    .setup (mm_setup),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // modulus register; its bit length is kept alongside for the Barrett shifts
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
      mod_len <= bit_len(MODULUS_RESET);
    end else if (cfg_write) begin
      modulus <= cfg_data;
      mod_len <= bit_len(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and requests to the divider and multiplier
  always_comb begin
    state_next = state;
    div_req    = '{start: 1'b0, dividend: '0};
    mm_req     = '{start: 1'b0, op_x: '0, op_y: '0};
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_bad || (modulus == MOD_W'(1))) begin
            state_next = ST_OUT;
          end else begin
            // mu = floor(2^(2L) / p)
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(1) << {mod_len, 1'b0};
            state_next       = ST_MU;
          end
        end
      end
      ST_MU: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(a_in);
          state_next       = ST_RED_A;
        end
      end
      ST_RED_A: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(b_in);
          state_next       = ST_RED_B;
        end
      end
      ST_RED_B: begin
        if (div_rsp.done) begin
          if (k_r == '0) begin
            state_next = ST_CHECK;
          end else begin
            mm_req     = '{start: 1'b1, op_x: MOD_W'(1), op_y: MOD_W'(1)};
            state_next = ST_FACT;
          end
        end
      end
      ST_FACT: begin
        // running product: the next factor issues as soon as the last one lands
        if (mm_rsp.done) begin
          if (idx == k_r) begin
            state_next = ST_CHECK;
          end else begin
            mm_req = '{start: 1'b1, op_x: mm_rsp.value,
                       op_y: MOD_W'(idx) + MOD_W'(1)};
          end
        end
      end
      ST_CHECK: begin
        if ((fac_n == '0) || (fac_kn == '0)) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_POW;
        end
      end
      ST_POW: begin
        if (pw_exp == '0) begin
          mm_req     = '{start: 1'b1, op_x: acc, op_y: pw_res};
          state_next = ST_ACC;
        end else if (pw_exp[0]) begin
          mm_req     = '{start: 1'b1, op_x: pw_res, op_y: pw_base};
          state_next = ST_POW_MUL;
        end else begin
          mm_req     = '{start: 1'b1, op_x: pw_base, op_y: pw_base};
          state_next = ST_POW_SQ;
        end
      end
      ST_POW_MUL: begin
        if (mm_rsp.done) begin
          if (pw_exp[MOD_W-1:1] == '0) begin
            state_next = ST_POW;
          end else begin
            mm_req     = '{start: 1'b1, op_x: pw_base, op_y: pw_base};
            state_next = ST_POW_SQ;
          end
        end
      end
      ST_POW_SQ: begin
        if (mm_rsp.done) state_next = ST_POW;
      end
      ST_ACC: begin
        if (mm_rsp.done) begin
          if (pow_sel == 2'd3) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_POW;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath registers, loaded as the sequencer steps
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          a_in    <= coef_a;
          b_in    <= coef_b;
          k_r     <= total_power;
          n_r     <= x_power;
          m_r     <= y_power;
          kn_r    <= total_power - x_power;
          acc     <= '0;
          res_inv <= req_bad;
        end
      end
      ST_MU: begin
        if (div_rsp.done) mu <= div_rsp.quotient[MU_W-1:0];
      end
      ST_RED_A: begin
        if (div_rsp.done) a_res <= div_rsp.remainder;
      end
      ST_RED_B: begin
        if (div_rsp.done) begin
          b_res  <= div_rsp.remainder;
          fac    <= MOD_W'(1);
          fac_n  <= MOD_W'(1);   // n = 0
          fac_kn <= MOD_W'(1);   // n = k
          idx    <= POW_W'(1);
        end
      end
      ST_FACT: begin
        if (mm_rsp.done) begin
          fac <= mm_rsp.value;
          if (idx == n_r)  fac_n  <= mm_rsp.value;
          if (idx == kn_r) fac_kn <= mm_rsp.value;
          idx <= idx + POW_W'(1);
        end
      end
      ST_CHECK: begin
        pw_res  <= MOD_W'(1);
        pw_base <= fac_n;
        pw_exp  <= modulus - MOD_W'(2);
        pow_sel <= 2'd0;
        if ((fac_n == '0) || (fac_kn == '0)) begin
          acc     <= '0;
          res_inv <= 1'b1;
        end else begin
          acc <= fac;
        end
      end
      ST_POW: begin
        if ((pw_exp != '0) && !pw_exp[0]) pw_exp <= pw_exp >> 1;
      end
      ST_POW_MUL: begin
        if (mm_rsp.done) begin
          pw_res <= mm_rsp.value;
          pw_exp <= pw_exp >> 1;
        end
      end
      ST_POW_SQ: begin
        if (mm_rsp.done) pw_base <= mm_rsp.value;
      end
      ST_ACC: begin
        if (mm_rsp.done) begin
          acc     <= mm_rsp.value;
          pow_sel <= pow_sel + 2'd1;
          pw_res  <= MOD_W'(1);
          case (pow_sel)
            2'd0: begin
              pw_base <= fac_kn;
              pw_exp  <= modulus - MOD_W'(2);
            end
            2'd1: begin
              pw_base <= a_res;
              pw_exp  <= MOD_W'(n_r);
            end
            2'd2: begin
              pw_base <= b_res;
              pw_exp  <= MOD_W'(m_r);
            end
            default: begin
              pw_base <= pw_base;
            end
          endcase
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // output register: holds a finished result until the far side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      coefficient <= acc;
      invalid     <= res_inv;
    end
  end

endmodule

@@ hw/rtl/btcmp_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module btcmp_divider import btcmp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [MOD_W-1:0] divisor,
  input  div_req_t         req,
  output div_rsp_t         rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     dvd;
  logic [DIV_W-1:0]     quo;
  logic [MOD_W-1:0]     rem;

  logic [MOD_W:0]       trial;
  logic                 fits;
  logic [MOD_W-1:0]     rem_next;

  assign trial    = {rem, dvd[DIV_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign rem_next = fits ? MOD_W'(trial - {1'b0, divisor}) : trial[MOD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == '0) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], 1'b0};
      rem <= rem_next;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp = '{done: done, quotient: quo, remainder: rem};

endmodule

@@ hw/rtl/btcmp_modmul.sv @@
// Modular multiplier, Barrett reduction against a run-time modulus; prod, q2, qp and value are registered in turn.
module btcmp_modmul import btcmp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mm_setup_t setup,
  input  mm_req_t   req,
  output mm_rsp_t   rsp
);

  logic [3:0]          stage;
  logic [PROD_W-1:0]   prod;
  logic [MU_W+15:0]    q2;
  logic [PROD_W-1:0]   qp;
  logic [MOD_W-1:0]    value;

  logic [PROD_W-1:0]   prod_full;
  logic [15:0]         q1;
  logic [MU_W+15:0]    q2_full;
  logic [16:0]         q3;
  logic [31:0]         qp_full;
  logic [PROD_W-1:0]   diff;
  logic [16:0]         rem_raw;
  logic [MOD_W:0]      two_p;
  logic [16:0]         rem_fix;
  logic [LEN_W:0]      shift_hi;

  assign prod_full = {{MOD_W{1'b0}}, req.op_x} * {{MOD_W{1'b0}}, req.op_y};

  // q1 = x >> (L-1), q3 = (q1 * mu) >> (L+1)
  assign q1       = 16'(prod >> (setup.len - LEN_W'(1)));
  assign q2_full  = {{MU_W{1'b0}}, q1} * {16'd0, setup.mu};
  assign shift_hi = {1'b0, setup.len} + (LEN_W+1)'(1);
  assign q3       = 17'(q2 >> shift_hi);
  assign qp_full  = {15'd0, q3} * {17'd0, setup.modulus};

  // remainder estimate is below 3p: at most two corrections
  assign diff    = prod - qp;
  assign rem_raw = diff[16:0];
  assign two_p   = {setup.modulus, 1'b0};

  always_comb begin
    if (rem_raw >= {1'b0, two_p}) begin
      rem_fix = rem_raw - {1'b0, two_p};
    end else if (rem_raw >= {2'b00, setup.modulus}) begin
      rem_fix = rem_raw - {2'b00, setup.modulus};
    end else begin
      rem_fix = rem_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= {stage[2:0], req.start};
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) prod  <= prod_full;
    if (stage[0])  q2    <= q2_full;
    if (stage[1])  qp    <= qp_full[PROD_W-1:0];
    if (stage[2])  value <= rem_fix[MOD_W-1:0];
  end

  assign rsp = '{done: stage[3], value: value};

endmodule

@@ hw/rtl/btcmp_checker.sv @@
// Port-level checks on the binomial term coefficient block, bound to the top level.
module btcmp_checker import btcmp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [MOD_W-1:0] coefficient,
  input logic             invalid
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(coefficient) && $stable(invalid))
    else $error("result changed while stalled");

  // an accepted transaction leaves the block busy in the cycle after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request side not busy after a transaction");

  // a new result appears as the sequencer returns to idle
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result presented while still busy");

  // an invalid request returns zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> coefficient == '0)
    else $error("invalid result with nonzero coefficient");

  // a residue never reaches the all-ones code
  a_coef_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> coefficient != {MOD_W{1'b1}})
    else $error("coefficient out of range");

endmodule

bind binomial_term_coefficient_mod_prime btcmp_checker u_checker (.*);

@@ tb/sv/tb_binomial_term_coefficient_mod_prime.sv @@
// Self-checking testbench for the binomial term coefficient modulo prime block.
module tb_binomial_term_coefficient_mod_prime;
  timeunit 1ns;
  timeprecision 1ps;

  import btcmp_pkg::*;

  // Timeout, reckoned several times over from the slowest plausible run:
  // ~300 transactions, most at k < 64 and the others at k up to 1023, plus sender
  // gaps and the long receiver hold-off.
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  // Settling time after the last result.
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  localparam int unsigned SMALL_K_CAP = 63;

  // Receiver behaviour for a phase.
  typedef enum logic [1:0] {
    RX_FREE,    // never stalls
    RX_CHOPPY,  // short stalls, short free runs
    RX_HEAVY    // long stalls, brief free windows
  } rx_mode_t;

  typedef struct {
    logic [MOD_W-1:0] coefficient;
    logic             invalid;
  } term_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [MOD_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [COEF_W-1:0] coef_a;
  logic [COEF_W-1:0] coef_b;
  logic [POW_W-1:0]  total_power;
  logic [POW_W-1:0]  x_power;
  logic [POW_W-1:0]  y_power;
  logic              out_valid;
  logic              out_stall;
  logic [MOD_W-1:0]  coefficient;
  logic              invalid;

  // Results still owed by the block, oldest first.
  term_t            expected_terms[$];
  // Our copy of the modulus register; tracks every write.
  logic [MOD_W-1:0] modulus_shadow;
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;

  // Sender pacing: steady suppresses gaps; burst_left counts items before the next gap.
  bit               steady;
  int unsigned      burst_left;
  // Receiver control, shared with its own process.
  rx_mode_t         rx_mode;
  int unsigned      hold_request;

  binomial_term_coefficient_mod_prime u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .coef_a      (coef_a),
    .coef_b      (coef_b),
    .total_power (total_power),
    .x_power     (x_power),
    .y_power     (y_power),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .coefficient (coefficient),
    .invalid     (invalid)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // base^expo mod p by square-and-multiply; p is at least 2 here.
  function automatic longint unsigned pow_residue(input longint unsigned base,
                                                  input longint unsigned expo,
                                                  input longint unsigned p);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1;
    sq  = base % p;
    while (expo > 0) begin
      if ((expo & 1) != 0) acc = (acc * sq) % p;
      expo = expo >> 1;
      sq   = (sq * sq) % p;
    end
    return acc % p;
  endfunction

  // C(k,n) * a^n * b^m mod p, with the invalid cases flagged and zeroed.
  function automatic term_t binomial_term(input logic [COEF_W-1:0] a,
                                          input logic [COEF_W-1:0] b,
                                          input logic [POW_W-1:0]  k,
                                          input logic [POW_W-1:0]  n,
                                          input logic [POW_W-1:0]  m,
                                          input logic [MOD_W-1:0]  p_bits);
    term_t           t;
    longint unsigned p;
    longint unsigned run;
    longint unsigned fac_n;
    longint unsigned fac_kn;
    longint unsigned acc;
    t.coefficient = '0;
    t.invalid     = 1'b0;
    p = p_bits;
    // bottom above top, top not below the modulus (covers a zero modulus), top above bound
    if (n > k || k >= p || k > MAX_POWER) begin
      t.invalid = 1'b1;
      return t;
    end
    // modulus of one: everything collapses to zero
    if (p == 1) return t;
    run    = 1 % p;
    fac_n  = 1;
    fac_kn = 1;
    if (n == 0) fac_n = run;
    if (k - n == 0) fac_kn = run;
    for (int i = 1; i <= k; i++) begin
      run = (run * i) % p;
      if (i == n) fac_n = run;
      if (i == k - n) fac_kn = run;
    end
    // a factorial vanishing mod p means a composite modulus: nothing to invert
    if (fac_n == 0 || fac_kn == 0) begin
      t.invalid = 1'b1;
      return t;
    end
    acc = run;
    acc = (acc * pow_residue(fac_n, p - 2, p)) % p;
    acc = (acc * pow_residue(fac_kn, p - 2, p)) % p;
    acc = (acc * pow_residue(a, n, p)) % p;
    acc = (acc * pow_residue(b, m, p)) % p;
    t.coefficient = acc[MOD_W-1:0];
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    term_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_terms.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: coefficient %0d invalid %0b", coefficient, invalid);
      end else begin
        want = expected_terms.pop_front();
        if (coefficient !== want.coefficient || invalid !== want.invalid) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected coefficient %0d invalid %0b, got %0d invalid %0b",
                     want.coefficient, want.invalid, coefficient, invalid);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("binomial_term_coefficient_mod_prime regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, plus an on-request long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned run_left;
    out_stall = 1'b0;
    run_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        // long hold-off, counted here; the block backs up and stalls its input
        out_stall <= 1'b1;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
        out_stall <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        case (rx_mode)
          RX_FREE: begin
            out_stall <= 1'b0;
          end
          RX_CHOPPY: begin
            out_stall <= ~out_stall;
            run_left = out_stall ? $urandom_range(0, 10) : $urandom_range(0, 4);
          end
          default: begin
            out_stall <= ~out_stall;
            run_left = out_stall ? $urandom_range(0, 3) : $urandom_range(5, 60);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // One request transaction; valid stays up afterwards unless a gap is due, so
  // back-to-back bursts see no dead cycle.
  task automatic send_term(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b,
                           input logic [POW_W-1:0] k, input logic [POW_W-1:0] n,
                           input logic [POW_W-1:0] m);
    int unsigned gap;
    @(negedge clk);
    coef_a      <= a;
    coef_b      <= b;
    total_power <= k;
    x_power     <= n;
    y_power     <= m;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_terms.push_back(binomial_term(a, b, k, n, m, modulus_shadow));
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // mostly short gaps, now and then one long enough to land mid-computation
        gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 900) : $urandom_range(1, 12);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(0, 6);
      end
    end
  endtask

  // Drop valid and wait for every owed result; the block is idle afterwards.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_data  <= value;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    modulus_shadow = value;
  endtask

  // Mostly well-formed requests (k below the modulus, n <= k) with random content;
  // the rest is raw noise or a bottom-above-top request.
  task automatic send_random_term(input int unsigned k_cap);
    logic [POW_W-1:0] k;
    logic [POW_W-1:0] n;
    logic [POW_W-1:0] m;
    int unsigned      pick;
    int unsigned      top;
    pick = $urandom_range(0, 99);
    m = ($urandom_range(0, 3) == 0) ? POW_W'($urandom_range(0, 3)) : POW_W'($urandom);
    if (modulus_shadow == 0 || pick < 10) begin
      k = POW_W'($urandom);
      n = POW_W'($urandom);
    end else if (pick < 15) begin
      k = POW_W'($urandom_range(0, MAX_POWER - 1));
      n = POW_W'($urandom_range(k + 1, MAX_POWER));
    end else begin
      // a few draw k up to the largest value the modulus allows
      top = (pick < 20) ? MAX_POWER : k_cap;
      if (top > modulus_shadow - 1) top = modulus_shadow - 1;
      k = POW_W'($urandom_range(0, top));
      n = POW_W'($urandom_range(0, k));
    end
    send_term(COEF_W'($urandom), COEF_W'($urandom), k, n, m);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset modulus 10007: zero powers, field extremes, zero residue of a,
  // bottom above top, and the largest total power.
  task automatic test_reset_modulus_edges();
    send_term('0, '0, 0, 0, 0);
    send_term('1, '1, 10, 3, 7);
    send_term(COEF_W'(30021), 5, 8, 4, 2);
    send_term('0, 9, 6, 0, 3);
    send_term(5, 6, 5, 6, 1);
    send_term('1, '1, 1023, 511, 1023);
    send_term(3, 4, 1023, 1023, 0);
    send_term(3, 4, 1023, 0, 1023);
  endtask

  // Smallest prime: only k of 0 and 1 are answerable.
  task automatic test_smallest_prime();
    write_modulus(2);
    send_term(1, 1, 1, 1, 1);
    send_term('0, '1, 1, 0, 5);
    send_term(1, 1, 2, 1, 1);
  endtask

  // Largest 15-bit prime, and the all-ones register value, which is composite
  // (7*31*151): factorials past 150 vanish and must be flagged.
  task automatic test_register_top();
    write_modulus(32749);
    send_term(20'hAAAAA, 20'h55555, 1023, 512, 1023);
    write_modulus('1);
    send_term(7, 11, 200, 160, 3);
    send_term(7, 11, 100, 50, 9);
    send_term('1, '1, 1023, 1, 1);
  endtask

  // Moduli of zero and one.
  task automatic test_degenerate_moduli();
    write_modulus(0);
    send_term(1, 1, 0, 0, 0);
    write_modulus(1);
    send_term(1, 1, 0, 0, 0);
    send_term(1, 1, 1, 0, 0);
  endtask

  // Small composite modulus: 3! is 0 mod 6, so neither inverse exists.
  task automatic test_zero_residue_inverse();
    write_modulus(6);
    send_term(1, 1, 5, 3, 0);
    send_term(1, 1, 5, 2, 4);
    send_term(2, 3, 2, 1, 1);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering, so
  // the result register and the working slot fill and in_stall rises; then the
  // sender waits for every result before moving on.
  task automatic test_back_pressure();
    write_modulus(13);
    steady  = 1'b1;
    rx_mode = RX_FREE;
    hold_request = HOLD_OFF_CYCLES;
    repeat (8) send_random_term(SMALL_K_CAP);
    steady = 1'b0;
    settle();
  endtask

  // A phase of random transactions under one modulus; quiet runs without any sender gaps.
  task automatic test_random_terms(input logic [MOD_W-1:0] value, input int unsigned count,
                                   input rx_mode_t mode, input bit quiet);
    write_modulus(value);
    rx_mode    = mode;
    steady     = quiet;
    burst_left = 0;
    repeat (count) send_random_term(SMALL_K_CAP);
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    coef_a         = '0;
    coef_b         = '0;
    total_power    = '0;
    x_power        = '0;
    y_power        = '0;
    modulus_shadow = MODULUS_RESET;
    steady         = 1'b0;
    burst_left     = 0;
    rx_mode        = RX_CHOPPY;
    hold_request   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_modulus_edges();
    test_smallest_prime();
    test_register_top();
    test_degenerate_moduli();
    test_zero_residue_inverse();
    test_back_pressure();
    test_random_terms(32749, 90, RX_CHOPPY, 1'b0);
    test_random_terms(MODULUS_RESET, 60, RX_HEAVY, 1'b0);
    test_random_terms(1031, 40, RX_FREE, 1'b1);
    test_random_terms(13, 40, RX_CHOPPY, 1'b0);
    test_random_terms('1, 30, RX_HEAVY, 1'b0);
    test_random_terms(2, 15, RX_CHOPPY, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += expected_terms.size();
    if (mismatch_count == 0)
      $display("binomial_term_coefficient_mod_prime regression: pass");
    else
      $display("binomial_term_coefficient_mod_prime regression: fail");
    $finish;
  end

endmodule

@@ binomial_term_coefficient_mod_prime.f @@
hw/rtl/btcmp_pkg.sv
hw/rtl/btcmp_divider.sv
hw/rtl/btcmp_modmul.sv
hw/rtl/binomial_term_coefficient_mod_prime.sv
hw/rtl/btcmp_checker.sv
tb/sv/tb_binomial_term_coefficient_mod_prime.sv
